@@ rtl/lflt_pkg.sv @@
// ---------------------------------------------------------------------------
// lflt_pkg
// Shared types, widths and codes of the login failure lockout table.
// ---------------------------------------------------------------------------
package lflt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int ADDR_W   = 32;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_DURATION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES   = 2'd2;

    localparam logic [TIME_W-1:0]  RST_LOCK_DURATION  = 32'd900;
    localparam logic [TIME_W-1:0]  RST_FAILURE_WINDOW = 32'd300;
    localparam logic [COUNT_W-1:0] RST_MAX_FAILURES   = 8'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_SUCCESS = 2'd0,
        ST_LOCKED  = 2'd1,
        ST_WRONG   = 2'd2
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic               locked;
        logic [COUNT_W-1:0] fail_count;
        logic [TIME_W-1:0]  last_fail;
        logic [TIME_W-1:0]  lock_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_CHECK,
        S_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic check;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

@@ rtl/lflt_req_if.sv @@
// ---------------------------------------------------------------------------
// lflt_req_if
// Login attempt channel: valid/ready handshake with the attempt payload.
// ---------------------------------------------------------------------------
interface lflt_req_if;
    import lflt_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] client_addr;
    logic [TIME_W-1:0] now_seconds;
    logic              credentials_ok;

    modport source (output valid, client_addr, now_seconds, credentials_ok, input ready);
    modport sink   (input valid, client_addr, now_seconds, credentials_ok, output ready);
endinterface

@@ rtl/lflt_rsp_if.sv @@
// ---------------------------------------------------------------------------
// lflt_rsp_if
// Verdict channel: valid/ready handshake with the verdict payload.
// ---------------------------------------------------------------------------
interface lflt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       became_locked;
    logic       entry_dropped;

    modport source (output valid, status, became_locked, entry_dropped, input ready);
    modport sink   (input valid, status, became_locked, entry_dropped, output ready);
endinterface

@@ rtl/login_failure_lockout_table.sv @@
// ---------------------------------------------------------------------------
// login_failure_lockout_table
// Brute-force login lockout over a small table of client addresses.
// ---------------------------------------------------------------------------
// Usage: one beat on req carries a login attempt (client_addr, now_seconds,
// credentials_ok); for each attempt exactly one beat leaves on rsp with the
// verdict (status, became_locked, entry_dropped).
// Configuration: cfg_wr_en with cfg_index 0 (lock duration), 1 (failure
// window) or 2 (max failures) and cfg_wdata; write only while idle.
// Timing: one attempt at a time. After acceptance the table is walked one
// entry per cycle through the RAM read port, then timers are checked and the
// entry written back: the verdict is registered with the write-back and a new
// attempt is taken once the sequencer is back in idle (states SCAN, DRAIN,
// CHECK, COMMIT, then IDLE).
// Stall: the verdict sits in an output register; a new attempt is accepted
// while it waits, and only the write-back of that attempt holds until rsp
// frees.
// Reset: all table entries are empty and the configuration returns to
// 900 s lock, 300 s window and a limit of 3 failures.
// ---------------------------------------------------------------------------
module login_failure_lockout_table (
    input  logic                            clk,
    input  logic                            rst_n,
    lflt_req_if.sink                        req,
    lflt_rsp_if.source                      rsp,
    input  logic                            cfg_wr_en,
    input  logic [lflt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lflt_pkg::CFG_W-1:0]      cfg_wdata
);
    import lflt_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    lflt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lflt_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .client_addr    (req.client_addr),
        .now_seconds    (req.now_seconds),
        .credentials_ok (req.credentials_ok),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .status         (rsp.status),
        .became_locked  (rsp.became_locked),
        .entry_dropped  (rsp.entry_dropped)
    );
endmodule

@@ rtl/lflt_ram.sv @@
// ---------------------------------------------------------------------------
// lflt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lflt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/lflt_ctrl.sv @@
// ---------------------------------------------------------------------------
// lflt_ctrl
// Sequencer: accept an attempt, walk the table, check timers, commit.
// ---------------------------------------------------------------------------
module lflt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lflt_pkg::dp_stat_t   stat,
    output lflt_pkg::ctrl_cmd_t  cmd
);
    import lflt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_CHECK;
            S_CHECK:  state_next = S_COMMIT;
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:   cmd.scan   = 1'b1;
            S_DRAIN:  cmd        = '0;
            S_CHECK:  cmd.check  = 1'b1;
            S_COMMIT: cmd.commit = stat.out_free;
            default:  cmd        = '0;
        endcase
    end
endmodule

@@ rtl/lflt_dpath.sv @@
// ---------------------------------------------------------------------------
// lflt_dpath
// Table storage, lookup walk, timer checks, entry update and verdict register.
// ---------------------------------------------------------------------------
module lflt_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lflt_pkg::ctrl_cmd_t             cmd,
    output lflt_pkg::dp_stat_t              stat,
    input  logic                            cfg_wr_en,
    input  logic [lflt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lflt_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [lflt_pkg::ADDR_W-1:0]     client_addr,
    input  logic [lflt_pkg::TIME_W-1:0]     now_seconds,
    input  logic                            credentials_ok,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic                            became_locked,
    output logic                            entry_dropped
);
    import lflt_pkg::*;

    logic [TIME_W-1:0]        lock_duration_reg;
    logic [TIME_W-1:0]        failure_window_reg;
    logic [COUNT_W-1:0]       max_failures_reg;

    logic [ADDR_W-1:0]        addr_reg;
    logic [TIME_W-1:0]        now_reg;
    logic                     ok_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic                     cmp_valid_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;

    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    entry_t                   hit_entry_reg;
    logic                     free_found_reg;
    logic [IDX_W-1:0]         free_idx_reg;

    logic                     expired_reg;
    logic                     window_reg;

    logic                     out_valid_reg;
    status_t                  status_reg;
    logic                     became_reg;
    logic                     dropped_reg;

    logic [ENTRY_W-1:0]       rd_bits;
    entry_t                   rd_entry;
    logic                     match;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    entry_t                   ram_wentry;

    logic                     lock_hold;
    logic                     lock_expired;
    logic                     live_hit;
    logic                     alloc_ok;
    logic [IDX_W-1:0]         alloc_idx;
    logic [COUNT_W-1:0]       count_base;
    logic [COUNT_W-1:0]       count_upd;
    logic                     lock_upd;
    logic                     lock_first;
    status_t                  status_next;
    logic                     became_next;
    logic                     dropped_next;

    lflt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (scan_idx_reg),
        .rdata (rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);
    assign match    = cmp_valid_reg && valid_reg[cmp_idx_reg] && (rd_entry.addr == addr_reg);

    assign stat.scan_last = (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_duration_reg  <= RST_LOCK_DURATION;
            failure_window_reg <= RST_FAILURE_WINDOW;
            max_failures_reg   <= RST_MAX_FAILURES;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LOCK_DURATION:  lock_duration_reg  <= cfg_wdata[TIME_W-1:0];
                CFG_FAILURE_WINDOW: failure_window_reg <= cfg_wdata[TIME_W-1:0];
                CFG_MAX_FAILURES:   max_failures_reg   <= cfg_wdata[COUNT_W-1:0];
                default:            max_failures_reg   <= max_failures_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= client_addr;
            now_reg  <= now_seconds;
            ok_reg   <= credentials_ok;
        end
        if (match && !hit_reg)
        begin
            hit_idx_reg   <= cmp_idx_reg;
            hit_entry_reg <= rd_entry;
        end
        if (cmp_valid_reg && !valid_reg[cmp_idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (cmd.check)
        begin
            expired_reg <= (now_reg - hit_entry_reg.lock_time) >= lock_duration_reg;
            window_reg  <= (now_reg - hit_entry_reg.last_fail) >= failure_window_reg;
        end
        if (cmd.commit)
        begin
            status_reg  <= status_next;
            became_reg  <= became_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan;
            valid_reg     <= valid_next;
            if (cmd.load)
            begin
                scan_idx_reg   <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan && !stat.scan_last)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmp_valid_reg && !valid_reg[cmp_idx_reg])
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign lock_hold    = hit_reg && hit_entry_reg.locked && !expired_reg;
    assign lock_expired = hit_reg && hit_entry_reg.locked && expired_reg;
    assign live_hit     = hit_reg && !hit_entry_reg.locked;
    assign alloc_ok     = lock_expired || free_found_reg;
    assign alloc_idx    = (lock_expired && (!free_found_reg || (hit_idx_reg < free_idx_reg)))
                          ? hit_idx_reg : free_idx_reg;
    assign count_base   = window_reg ? '0 : hit_entry_reg.fail_count;
    assign count_upd    = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
    assign lock_upd     = count_upd >= max_failures_reg;
    assign lock_first   = max_failures_reg <= COUNT_W'(1);

    always_comb
    begin
        valid_next   = valid_reg;
        ram_we       = 1'b0;
        ram_waddr    = hit_idx_reg;
        ram_wentry   = hit_entry_reg;
        status_next  = ST_WRONG;
        became_next  = 1'b0;
        dropped_next = 1'b0;
        if (lock_hold)
        begin
            status_next = ST_LOCKED;
        end
        else if (ok_reg)
        begin
            status_next = ST_SUCCESS;
            if (cmd.commit && hit_reg)
            begin
                valid_next[hit_idx_reg] = 1'b0;
            end
        end
        else if (live_hit)
        begin
            ram_we               = cmd.commit;
            ram_wentry.fail_count = count_upd;
            ram_wentry.last_fail = now_reg;
            ram_wentry.locked    = lock_upd;
            if (lock_upd)
            begin
                ram_wentry.lock_time = now_reg;
            end
            became_next = lock_upd;
        end
        else
        begin
            if (cmd.commit && lock_expired)
            begin
                valid_next[hit_idx_reg] = 1'b0;
            end
            if (alloc_ok)
            begin
                ram_we                = cmd.commit;
                ram_waddr             = alloc_idx;
                ram_wentry.addr       = addr_reg;
                ram_wentry.locked     = lock_first;
                ram_wentry.fail_count = COUNT_W'(1);
                ram_wentry.last_fail  = now_reg;
                ram_wentry.lock_time  = lock_first ? now_reg : '0;
                became_next           = lock_first;
                if (cmd.commit)
                begin
                    valid_next[alloc_idx] = 1'b1;
                end
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign became_locked = became_reg;
    assign entry_dropped = dropped_reg;
endmodule
